// ===== rtl/core/etrs_pkg.sv =====
package etrs_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int QUAD_FRAC  = ANGLE_BITS - 2;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] POLY_A  = 31'd1686629713;
    localparam logic [30:0] POLY_B  = 31'd688904866;
    localparam logic [30:0] POLY_C  = 31'd76016977;

    localparam logic signed [23:0] TERM_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TERM_MIN = -24'sh800000;

    typedef logic signed [31:0] t_trig;

    typedef struct packed {
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_side;

    // v / 2^30, round half away from zero
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        m = (m + 64'd536870912) >> 30;
        return v[63] ? $signed(64'd0 - m) : $signed(m);
    endfunction

endpackage

// ===== rtl/core/euler_trs_model_matrix.sv =====
// channel | beat fields                                   | handshake
// in      | angle_x/y/z, scale_x/y/z, shift_x/y/z          | i_valid / o_stall
// out     | c0_r0..c2_r2 (Q8.16), c3_r0..c3_r2 (Q16.16)    | o_valid / i_stall
// One beat per cycle sustained while the output is not stalled; 12 register
// stages (input reg, 4-stage sine polynomial, quadrant map, two multiply/round
// levels, scale multiply, clamp).
// Reset clears only the stage valid bits.
// A stalled output holds the whole pipeline; no beat is dropped or repeated.
module euler_trs_model_matrix
    import etrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_angle_x,
    input  logic [15:0]        i_angle_y,
    input  logic [15:0]        i_angle_z,
    input  logic signed [23:0] i_scale_x,
    input  logic signed [23:0] i_scale_y,
    input  logic signed [23:0] i_scale_z,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_shift_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_c0_r0,
    output logic signed [23:0] o_c0_r1,
    output logic signed [23:0] o_c0_r2,
    output logic signed [23:0] o_c1_r0,
    output logic signed [23:0] o_c1_r1,
    output logic signed [23:0] o_c1_r2,
    output logic signed [23:0] o_c2_r0,
    output logic signed [23:0] o_c2_r1,
    output logic signed [23:0] o_c2_r2,
    output logic signed [31:0] o_c3_r0,
    output logic signed [31:0] o_c3_r1,
    output logic signed [31:0] o_c3_r2
);

    localparam int NSTG = 12;

    localparam int P_CZCY = 0;
    localparam int P_CZSY = 1;
    localparam int P_CXSZ = 2;
    localparam int P_CXCZ = 3;
    localparam int P_SXSZ = 4;
    localparam int P_SZCY = 5;
    localparam int P_SXSY = 6;
    localparam int P_CXSY = 7;
    localparam int P_CZSX = 8;
    localparam int P_CYSX = 9;
    localparam int P_CXCY = 10;

    localparam int Q_B = 0;
    localparam int Q_D = 1;
    localparam int Q_G = 2;
    localparam int Q_H = 3;

    logic             w_en;
    logic [NSTG-1:0]  r_vld;
    t_side            r_side [0:11];
    t_side            n_side;
    logic [1:0]       r_quad [0:4][0:2];
    logic [1:0]       n_quad [0:2];
    logic [30:0]      r_xs   [0:2];
    logic [30:0]      r_xc   [0:2];
    logic [30:0]      w_ps   [0:2];
    logic [30:0]      w_pc   [0:2];
    t_trig            r_sn   [0:2];
    t_trig            r_cs   [0:2];
    t_trig            n_sn   [0:2];
    t_trig            n_cs   [0:2];
    logic [15:0]      w_ang  [0:2];

    logic signed [63:0] r_p1  [0:10];
    t_trig              r_sn6 [0:2];
    t_trig              r_r1  [0:10];
    t_trig              r_sn7 [0:2];
    logic signed [63:0] r_p2  [0:3];
    t_trig              r_r1b [0:10];
    t_trig              r_sy8;
    logic signed [33:0] r_term [0:8];
    logic signed [33:0] n_term [0:8];
    logic signed [57:0] r_sp  [0:8];
    logic signed [23:0] w_sc  [0:8];
    logic signed [23:0] r_out [0:8];
    logic signed [63:0] n_rnd [0:8];

    assign w_en    = !r_vld[NSTG-1] || !i_stall;
    assign o_stall = r_vld[NSTG-1] && i_stall;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    assign w_ang[0] = i_angle_x;
    assign w_ang[1] = i_angle_y;
    assign w_ang[2] = i_angle_z;

    always_comb begin
        n_side.scale_x = i_scale_x;
        n_side.scale_y = i_scale_y;
        n_side.scale_z = i_scale_z;
        n_side.shift_x = i_shift_x;
        n_side.shift_y = i_shift_y;
        n_side.shift_z = i_shift_z;
        for (int a = 0; a < 3; a++) begin
            n_quad[a] = w_ang[a][ANGLE_BITS-1 -: 2];
        end
    end

    // stage 0: quarter-turn fraction in Q30 and its complement
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int a = 0; a < 3; a++) begin
                r_quad[0][a] <= n_quad[a];
                r_xs[a] <= 31'({w_ang[a][QUAD_FRAC-1:0], (30 - QUAD_FRAC)'(0)});
                r_xc[a] <= ONE_Q30
                         - 31'({w_ang[a][QUAD_FRAC-1:0], (30 - QUAD_FRAC)'(0)});
            end
            for (int s = 1; s <= 11; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int s = 1; s <= 4; s++) begin
                r_quad[s] <= r_quad[s-1];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_trig
        etrs_qsine u_sin (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (r_xs[a]),
            .o_p   (w_ps[a])
        );
        etrs_qsine u_cos (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (r_xc[a]),
            .o_p   (w_pc[a])
        );
    end

    // stage 5: quadrant fold
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            case (r_quad[4][a])
                2'd0: begin
                    n_sn[a] = t_trig'({1'b0, w_ps[a]});
                    n_cs[a] = t_trig'({1'b0, w_pc[a]});
                end
                2'd1: begin
                    n_sn[a] = t_trig'({1'b0, w_pc[a]});
                    n_cs[a] = -t_trig'({1'b0, w_ps[a]});
                end
                2'd2: begin
                    n_sn[a] = -t_trig'({1'b0, w_ps[a]});
                    n_cs[a] = -t_trig'({1'b0, w_pc[a]});
                end
                default: begin
                    n_sn[a] = -t_trig'({1'b0, w_pc[a]});
                    n_cs[a] = t_trig'({1'b0, w_ps[a]});
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_sn[a] <= n_sn[a];
                r_cs[a] <= n_cs[a];
            end
        end
    end

    // stages 6-7: first-level products, then rounding
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1[P_CZCY] <= 64'(r_cs[2]) * 64'(r_cs[1]);
            r_p1[P_CZSY] <= 64'(r_cs[2]) * 64'(r_sn[1]);
            r_p1[P_CXSZ] <= 64'(r_cs[0]) * 64'(r_sn[2]);
            r_p1[P_CXCZ] <= 64'(r_cs[0]) * 64'(r_cs[2]);
            r_p1[P_SXSZ] <= 64'(r_sn[0]) * 64'(r_sn[2]);
            r_p1[P_SZCY] <= 64'(r_sn[2]) * 64'(r_cs[1]);
            r_p1[P_SXSY] <= 64'(r_sn[0]) * 64'(r_sn[1]);
            r_p1[P_CXSY] <= 64'(r_cs[0]) * 64'(r_sn[1]);
            r_p1[P_CZSX] <= 64'(r_cs[2]) * 64'(r_sn[0]);
            r_p1[P_CYSX] <= 64'(r_cs[1]) * 64'(r_sn[0]);
            r_p1[P_CXCY] <= 64'(r_cs[0]) * 64'(r_cs[1]);
            for (int a = 0; a < 3; a++) begin
                r_sn6[a] <= r_sn[a];
                r_sn7[a] <= r_sn6[a];
            end
            for (int k = 0; k <= 10; k++) begin
                r_r1[k] <= t_trig'(rnd30(r_p1[k]));
            end
        end
    end

    // stage 8: second-level products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2[Q_B] <= 64'(r_r1[P_CZSY]) * 64'(r_sn7[0]);
            r_p2[Q_D] <= 64'(r_r1[P_CXCZ]) * 64'(r_sn7[1]);
            r_p2[Q_G] <= 64'(r_r1[P_SXSY]) * 64'(r_sn7[2]);
            r_p2[Q_H] <= 64'(r_r1[P_CXSY]) * 64'(r_sn7[2]);
            r_r1b     <= r_r1;
            r_sy8     <= r_sn7[1];
        end
    end

    // stage 9: matrix terms in Q30
    always_comb begin
        n_term[0] = 34'(r_r1b[P_CZCY]);
        n_term[1] = 34'(rnd30(r_p2[Q_B])) - 34'(r_r1b[P_CXSZ]);
        n_term[2] = 34'(rnd30(r_p2[Q_D])) + 34'(r_r1b[P_SXSZ]);
        n_term[3] = 34'(r_r1b[P_SZCY]);
        n_term[4] = 34'(rnd30(r_p2[Q_G])) + 34'(r_r1b[P_CXCZ]);
        n_term[5] = 34'(rnd30(r_p2[Q_H])) - 34'(r_r1b[P_CZSX]);
        n_term[6] = -34'(r_sy8);
        n_term[7] = 34'(r_r1b[P_CYSX]);
        n_term[8] = 34'(r_r1b[P_CXCY]);
    end

    assign w_sc[0] = r_side[9].scale_x;
    assign w_sc[1] = r_side[9].scale_x;
    assign w_sc[2] = r_side[9].scale_x;
    assign w_sc[3] = r_side[9].scale_y;
    assign w_sc[4] = r_side[9].scale_y;
    assign w_sc[5] = r_side[9].scale_y;
    assign w_sc[6] = r_side[9].scale_z;
    assign w_sc[7] = r_side[9].scale_z;
    assign w_sc[8] = r_side[9].scale_z;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_rnd[k] = rnd30(64'(r_sp[k]));
        end
    end

    // stages 10-11: scale multiply, round and clamp
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_term[k] <= n_term[k];
                r_sp[k]   <= 58'(w_sc[k]) * 58'(r_term[k]);
                if (n_rnd[k] > 64'(TERM_MAX)) begin
                    r_out[k] <= TERM_MAX;
                end else if (n_rnd[k] < 64'(TERM_MIN)) begin
                    r_out[k] <= TERM_MIN;
                end else begin
                    r_out[k] <= n_rnd[k][23:0];
                end
            end
        end
    end

    assign o_c0_r0 = r_out[0];
    assign o_c0_r1 = r_out[1];
    assign o_c0_r2 = r_out[2];
    assign o_c1_r0 = r_out[3];
    assign o_c1_r1 = r_out[4];
    assign o_c1_r2 = r_out[5];
    assign o_c2_r0 = r_out[6];
    assign o_c2_r1 = r_out[7];
    assign o_c2_r2 = r_out[8];
    assign o_c3_r0 = r_side[11].shift_x;
    assign o_c3_r1 = r_side[11].shift_y;
    assign o_c3_r2 = r_side[11].shift_z;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("stage valids moved while stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted beat not captured");

    a_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_sn[1] <= 32'sd1073741824) && (r_sn[1] >= -32'sd1073741824)
                  && (r_cs[1] <= 32'sd1073741824) && (r_cs[1] >= -32'sd1073741824))
        else $error("sine or cosine out of unit range");

endmodule

// ===== rtl/core/etrs_qsine.sv =====
module etrs_qsine
    import etrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [30:0] o_p
);

    logic [30:0] r_x1, r_x2a, r_x3;
    logic [30:0] r_sq, r_sq2;
    logic [30:0] r_t2, r_t3, r_p;
    logic [61:0] n_sq, n_m2, n_m3, n_m4;

    assign n_sq = 62'(i_x) * 62'(i_x);
    assign n_m2 = 62'(POLY_C) * 62'(r_sq);
    assign n_m3 = 62'(r_t2) * 62'(r_sq2);
    assign n_m4 = 62'(r_t3) * 62'(r_x3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1  <= i_x;
            r_sq  <= n_sq[60:30];
            r_x2a <= r_x1;
            r_sq2 <= r_sq;
            r_t2  <= POLY_B - n_m2[60:30];
            r_x3  <= r_x2a;
            r_t3  <= POLY_A - n_m3[60:30];
            r_p   <= n_m4[60:30];
        end
    end

    assign o_p = r_p;

endmodule

// ===== tb/sv/tb_euler_trs_model_matrix.sv =====
`timescale 1ns / 100ps

module tb_euler_trs_model_matrix;
    import etrs_pkg::*;

    typedef struct {
        logic [15:0]        ax, ay, az;
        logic signed [23:0] kx, ky, kz;
        logic signed [31:0] tx, ty, tz;
    } t_pose;

    typedef struct {
        logic signed [23:0] m [9];
        logic signed [31:0] t [3];
    } t_matrix;

    class matrix_scoreboard;
        t_matrix pending[$];
        int      n_bad;

        function longint quarter_sin(longint x);
            longint x2, t;
            x2 = (x * x) >>> 30;
            t  = (76016977 * x2) >>> 30;
            t  = 688904866 - t;
            t  = (t * x2) >>> 30;
            t  = 1686629713 - t;
            return (t * x) >>> 30;
        endfunction

        function void sincos(logic [15:0] a, output longint s, output longint c);
            longint x, p, q;
            x = longint'(a[13:0]) << 16;
            p = quarter_sin(x);
            q = quarter_sin(64'd1073741824 - x);
            case (a[15:14])
                2'd0: begin s = p;  c = q;  end
                2'd1: begin s = q;  c = -p; end
                2'd2: begin s = -p; c = -q; end
                default: begin s = -q; c = p; end
            endcase
        endfunction

        function longint round30(longint v);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (64'sd1 << 29)) >>> 30;
            return (v < 0) ? -m : m;
        endfunction

        function longint mq(longint a, longint b);
            return round30(a * b);
        endfunction

        function logic signed [23:0] clamp_scaled(longint k, longint term);
            longint r;
            r = round30(k * term);
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r[23:0];
        endfunction

        function void note_pose(t_pose p);
            longint sx, cx, sy, cy, sz, cz;
            t_matrix e;
            sincos(p.ax, sx, cx);
            sincos(p.ay, sy, cy);
            sincos(p.az, sz, cz);
            e.m[0] = clamp_scaled(p.kx, mq(cz, cy));
            e.m[1] = clamp_scaled(p.kx, mq(mq(cz, sy), sx) - mq(cx, sz));
            e.m[2] = clamp_scaled(p.kx, mq(mq(cx, cz), sy) + mq(sx, sz));
            e.m[3] = clamp_scaled(p.ky, mq(sz, cy));
            e.m[4] = clamp_scaled(p.ky, mq(mq(sx, sy), sz) + mq(cx, cz));
            e.m[5] = clamp_scaled(p.ky, mq(mq(cx, sy), sz) - mq(cz, sx));
            e.m[6] = clamp_scaled(p.kz, -sy);
            e.m[7] = clamp_scaled(p.kz, mq(cy, sx));
            e.m[8] = clamp_scaled(p.kz, mq(cx, cy));
            e.t[0] = p.tx;
            e.t[1] = p.ty;
            e.t[2] = p.tz;
            pending.push_back(e);
        endfunction

        function void check_matrix(t_matrix got);
            t_matrix e;
            bit bad;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected output beat");
                return;
            end
            e = pending.pop_front();
            bad = 0;
            for (int i = 0; i < 9; i++) if (got.m[i] !== e.m[i]) begin
                bad = 1;
                if (n_bad < 10) $display("term %0d: exp %0d got %0d", i, e.m[i], got.m[i]);
            end
            for (int i = 0; i < 3; i++) if (got.t[i] !== e.t[i]) begin
                bad = 1;
                if (n_bad < 10) $display("shift %0d: exp %0d got %0d", i, e.t[i], got.t[i]);
            end
            if (bad) n_bad++;
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [15:0] i_angle_x, i_angle_y, i_angle_z;
    logic signed [23:0] i_scale_x, i_scale_y, i_scale_z;
    logic signed [31:0] i_shift_x, i_shift_y, i_shift_z;
    logic signed [23:0] o_c0_r0, o_c0_r1, o_c0_r2, o_c1_r0, o_c1_r1, o_c1_r2;
    logic signed [23:0] o_c2_r0, o_c2_r1, o_c2_r2;
    logic signed [31:0] o_c3_r0, o_c3_r1, o_c3_r2;

    euler_trs_model_matrix dut (.*);

    matrix_scoreboard sb = new();
    int idle_pct, stall_pct;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_matrix got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.m = '{o_c0_r0, o_c0_r1, o_c0_r2, o_c1_r0, o_c1_r1, o_c1_r2,
                      o_c2_r0, o_c2_r1, o_c2_r2};
            got.t = '{o_c3_r0, o_c3_r1, o_c3_r2};
            sb.check_matrix(got);
        end
    end

    task automatic send_pose(t_pose p);
        while (($urandom_range(99) < idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_angle_x <= p.ax; i_angle_y <= p.ay; i_angle_z <= p.az;
        i_scale_x <= p.kx; i_scale_y <= p.ky; i_scale_z <= p.kz;
        i_shift_x <= p.tx; i_shift_y <= p.ty; i_shift_z <= p.tz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_pose(p);
    endtask

    function automatic logic signed [23:0] pick_scale();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'sh010000;
            3: return -24'sh010000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(4))
            0: return 16'($urandom_range(3)) << 14;
            1: return (16'($urandom_range(3)) << 14) | 16'h3FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pose random_pose();
        t_pose p;
        p.ax = pick_angle(); p.ay = pick_angle(); p.az = pick_angle();
        p.kx = pick_scale(); p.ky = pick_scale(); p.kz = pick_scale();
        p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
        return p;
    endfunction

    initial begin
        t_pose p;
        i_rst_n = 1'b0; i_valid = 1'b0;
        {i_angle_x, i_angle_y, i_angle_z} = '0;
        {i_scale_x, i_scale_y, i_scale_z} = '0;
        {i_shift_x, i_shift_y, i_shift_z} = '0;
        idle_pct = 0; stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // quadrant edges, scale extremes, translation extremes
        for (int q = 0; q < 4; q++) begin
            p.ax = 16'(q) << 14; p.ay = 16'(q) << 14; p.az = 16'(q) << 14;
            p.kx = 24'sh7FFFFF; p.ky = -24'sh800000; p.kz = -24'sh800000;
            p.tx = 32'sh7FFFFFFF; p.ty = 32'sh80000000; p.tz = '0;
            send_pose(p);
            p.ax = 16'hFFFF; p.ay = (16'(q) << 14) | 16'h3FFF; p.az = 16'h2000;
            p.kx = 24'sh010000; p.ky = -24'sh800000; p.kz = 24'sh7FFFFF;
            p.tx = -32'sd1; p.ty = 32'sd1; p.tz = 32'sh80000000;
            send_pose(p);
        end
        p.ax = 16'h2000; p.ay = 16'h2000; p.az = 16'h2000;
        p.kx = -24'sh800000; p.ky = -24'sh800000; p.kz = 24'sh7FFFFF;
        send_pose(p);
        p.ax = '0; p.ay = '0; p.az = '0;
        p.kx = '0; p.ky = '0; p.kz = '0;
        send_pose(p);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                3: begin idle_pct = 32; stall_pct = 32; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 300; n++) send_pose(random_pose());
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.n_bad == 0) $display("euler_trs_model_matrix: match");
        else $display("euler_trs_model_matrix: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("euler_trs_model_matrix: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/etrs_pkg.sv
rtl/core/etrs_qsine.sv
rtl/core/euler_trs_model_matrix.sv
tb/sv/tb_euler_trs_model_matrix.sv
